### src/xee_pkg.sv
`default_nettype none
package xee_pkg;

  localparam int CHAR_BITS = 16;
  localparam int NUM_ENT   = 14;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ENTITY,
    KIND_NUMERIC
  } item_kind_t;

  typedef struct packed {
    item_kind_t           kind;
    logic [3:0]           ent_idx;
    logic [CHAR_BITS-1:0] value;
    logic [2:0]           ndig;
  } entry_t;

  localparam logic [15:0] CH_AMP  = 16'h0026;
  localparam logic [15:0] CH_HASH = 16'h0023;
  localparam logic [15:0] CH_SEMI = 16'h003B;
  localparam logic [15:0] CH_ZERO = 16'h0030;

  // Entity table in lookup priority order
  localparam logic [15:0] ENT_CODE [NUM_ENT] = '{
    16'h0022, 16'h0026, 16'h0027, 16'h003C, 16'h003E,
    16'h000A, 16'h000D, 16'h0009,
    16'h00A0, 16'h00A9, 16'h00AE, 16'h20AC, 16'h2122, 16'h2764
  };

  // Names right-justified, one byte per character
  localparam logic [39:0] ENT_NAME [NUM_ENT] = '{
    40'("quot"), 40'("amp"), 40'("apos"), 40'("lt"), 40'("gt"),
    40'("#10"), 40'("#13"), 40'("#9"),
    40'("nbsp"), 40'("copy"), 40'("reg"), 40'("euro"), 40'("trade"), 40'("heart")
  };

  // Full run length including '&' and ';'
  localparam logic [3:0] ENT_LEN [NUM_ENT] = '{
    4'd6, 4'd5, 4'd6, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd4,
    4'd6, 4'd6, 4'd5, 4'd6, 4'd7, 4'd7
  };

  // Name character for a run position between the '&' and the ';'
  function automatic logic [7:0] ent_unit(input logic [3:0] idx, input logic [2:0] pos);
    logic [3:0] off;
    off = ENT_LEN[idx] - 4'd2 - {1'b0, pos};
    return ENT_NAME[idx][{off[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic [16:0] pow10(input logic [2:0] k);
    logic [16:0] p;
    case (k)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

### src/xee_front.sv
`default_nettype none
module xee_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [15:0]     code_unit,
  input  wire logic            q_full,
  output logic                 push,
  output xee_pkg::entry_t      push_entry
);
  import xee_pkg::*;

  logic       ascii_mode;
  logic       drop;
  logic       hit;
  logic [3:0] hit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      ascii_mode <= cfg_wr_data;
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = 4'd0;
    for (int i = NUM_ENT - 1; i >= 0; i--) begin
      if (code_unit == ENT_CODE[i]) begin
        hit     = 1'b1;
        hit_idx = 4'(i);
      end
    end
  end

  always_comb begin
    drop               = 1'b0;
    push_entry.kind    = KIND_PASS;
    push_entry.ent_idx = hit_idx;
    push_entry.value   = code_unit;
    if (code_unit >= 16'd10000)     push_entry.ndig = 3'd5;
    else if (code_unit >= 16'd1000) push_entry.ndig = 3'd4;
    else if (code_unit >= 16'd100)  push_entry.ndig = 3'd3;
    else if (code_unit >= 16'd10)   push_entry.ndig = 3'd2;
    else                            push_entry.ndig = 3'd1;

    if (!ascii_mode && code_unit == 16'd0) begin
      drop = 1'b1;
    end else if (hit) begin
      push_entry.kind = KIND_ENTITY;
    end else if (!ascii_mode) begin
      drop = (code_unit < 16'd32);
    end else if (code_unit < 16'd32 || code_unit > 16'd126) begin
      push_entry.kind = KIND_NUMERIC;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && !drop;

endmodule
`default_nettype wire

### src/xee_queue.sv
`default_nettype none
module xee_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire xee_pkg::entry_t  push_entry,
  input  wire logic             pop,
  output logic                  head_valid,
  output xee_pkg::entry_t       head,
  output logic                  full
);
  import xee_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign full       = (count == CW'(DEPTH));

endmodule
`default_nettype wire

### src/xee_back.sv
`default_nettype none
module xee_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire xee_pkg::entry_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [15:0]           out_char,
  output logic                  last
);
  import xee_pkg::*;

  logic [2:0]  pos;
  logic [15:0] rem;

  logic        load;
  logic        emit;
  logic [3:0]  run_len;
  logic        is_last;
  logic        digit_phase;
  logic [15:0] rem_src;
  logic [2:0]  k;
  logic [16:0] p;
  logic [3:0]  dig;
  logic [16:0] w;
  logic [15:0] ch;

  assign load    = !out_valid || !out_stall;
  assign emit    = head_valid && load;
  assign rem_src = (pos == 3'd0) ? head.value : rem;
  assign k       = 3'(head.ndig + 3'd1 - pos);
  assign p       = pow10(k);

  always_comb begin
    unique case (head.kind)
      KIND_PASS:    run_len = 4'd1;
      KIND_ENTITY:  run_len = ENT_LEN[head.ent_idx];
      KIND_NUMERIC: run_len = {1'b0, head.ndig} + 4'd3;
      default:      run_len = 4'd1;
    endcase
  end

  assign is_last     = ({1'b0, pos} == run_len - 4'd1);
  assign digit_phase = (pos >= 3'd2) && !is_last;

  // Digit is the largest multiple of the current power that still fits
  always_comb begin
    dig = 4'd0;
    w   = 17'd0;
    for (int j = 1; j <= 9; j++) begin
      if ({1'b0, rem_src} >= 17'(j) * p) begin
        dig = 4'(j);
        w   = 17'(j) * p;
      end
    end
  end

  always_comb begin
    unique case (head.kind)
      KIND_PASS: ch = head.value;
      KIND_ENTITY: begin
        if (pos == 3'd0)  ch = CH_AMP;
        else if (is_last) ch = CH_SEMI;
        else              ch = {8'h00, ent_unit(head.ent_idx, pos)};
      end
      KIND_NUMERIC: begin
        if (pos == 3'd0)      ch = CH_AMP;
        else if (pos == 3'd1) ch = CH_HASH;
        else if (is_last)     ch = CH_SEMI;
        else                  ch = CH_ZERO + {12'd0, dig};
      end
      default: ch = head.value;
    endcase
  end

  assign pop = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= emit;
      end
      if (emit) begin
        pos <= is_last ? 3'd0 : pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= ch;
      last     <= is_last;
      rem      <= digit_phase ? rem_src - w[15:0] : rem_src;
    end
  end

endmodule
`default_nettype wire

### src/xml_entity_escape_encoder_unit.sv
// XML entity escape encoder.
// Input channel: in_valid / in_stall with code_unit (16 bits); a transaction
// completes on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_char and last; last marks the
// final unit of the escaped run belonging to one input code unit.
// Each input yields 0 to 8 output units: entity names, &#decimal; in ASCII
// mode, pass-through, or nothing for dropped controls in plain mode.
// Configuration: cfg_wr_en / cfg_wr_data write ascii_mode (reset 0).
// Path: an input enters the queue; its output units are then registered.
// Throughput: while out_stall is low the back end emits one output unit per
// cycle and pops an input with its run's last unit; single-unit inputs flow
// at one per cycle. Dropped inputs never enter the queue. A DEPTH-entry queue
// between classifier and emitter absorbs runs; in_stall is high when full.
// While out_valid and out_stall are high the output register holds and the
// emitter waits; input transactions continue until the queue fills.
// Reset clears the queue, out_valid and ascii_mode.
`default_nettype none
module xml_entity_escape_encoder_unit #(
  parameter int DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] code_unit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_char,
  output logic             last
);
  import xee_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  xee_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_unit   (code_unit),
    .q_full      (q_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  xee_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  xee_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .last       (last)
  );

endmodule
`default_nettype wire

### src/xee_checker.sv
`default_nettype none
module xee_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_char,
  input wire logic        last
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_controls: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_char >= 16'd32)
    else $error("control code unit emitted");

  a_semi_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == 16'h003B |-> last)
    else $error("semicolon not at end of run");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
    else $error("stalled output changed");

endmodule

bind xml_entity_escape_encoder_unit xee_checker u_xee_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .last      (last)
);
`default_nettype wire

### test/escape_checker.sv
`timescale 1ns / 1ps
module escape_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] code_unit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_char,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  localparam logic [15:0] U_AMP    = 16'h0026;
  localparam logic [15:0] U_HASH   = 16'h0023;
  localparam logic [15:0] U_SEMI   = 16'h003B;
  localparam logic [15:0] U_DIGIT0 = 16'h0030;

  typedef struct packed {
    logic [15:0] ch;
    logic        fin;
  } esc_unit_t;

  esc_unit_t escaped_q[$];
  logic      asc_mode;

  function automatic string entity_name(input logic [15:0] c);
    case (c)
      16'h0022: return "quot";
      16'h0026: return "amp";
      16'h0027: return "apos";
      16'h003C: return "lt";
      16'h003E: return "gt";
      16'h000A: return "#10";
      16'h000D: return "#13";
      16'h0009: return "#9";
      16'h00A0: return "nbsp";
      16'h00A9: return "copy";
      16'h00AE: return "reg";
      16'h20AC: return "euro";
      16'h2122: return "trade";
      16'h2764: return "heart";
      default:  return "";
    endcase
  endfunction

  task automatic predict_escape(input logic [15:0] c, input logic asc);
    string       nm;
    logic [15:0] run[$];
    logic [15:0] digits[$];
    int          v;
    esc_unit_t   u;
    nm = entity_name(c);
    if (!asc && c == 16'h0000) return;
    if (nm.len() != 0) begin
      run.push_back(U_AMP);
      for (int i = 0; i < nm.len(); i++) run.push_back({8'h00, nm[i]});
      run.push_back(U_SEMI);
    end else if (!asc) begin
      if (c >= 16'd32) run.push_back(c);
    end else if (c >= 16'd32 && c <= 16'd126) begin
      run.push_back(c);
    end else begin
      v = c;
      do begin
        digits.push_front(U_DIGIT0 + 16'(v % 10));
        v = v / 10;
      end while (v != 0);
      run.push_back(U_AMP);
      run.push_back(U_HASH);
      foreach (digits[i]) run.push_back(digits[i]);
      run.push_back(U_SEMI);
    end
    foreach (run[i]) begin
      u.ch  = run[i];
      u.fin = (i == run.size() - 1);
      escaped_q.push_back(u);
    end
  endtask

  always @(posedge clk) begin
    esc_unit_t want;
    if (rst) begin
      asc_mode   = 1'b0;
      fail_count = 0;
      escaped_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (escaped_q.size() == 0) begin
          $error("out_char: no transaction expected, got %h (last %b)", out_char, last);
          fail_count++;
        end else begin
          want = escaped_q.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char);
            fail_count++;
          end
          if (last !== want.fin) begin
            $error("last: expected %b, got %b", want.fin, last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_escape(code_unit, asc_mode);
      if (cfg_wr_en) asc_mode = cfg_wr_data;
    end
    pending = escaped_q.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD  = 100;

  localparam logic MODE_PLAIN = 1'b0;
  localparam logic MODE_ASCII = 1'b1;

  localparam logic [15:0] ENTITY_CODES [14] = '{
    16'h0022, 16'h0026, 16'h0027, 16'h003C, 16'h003E,
    16'h000A, 16'h000D, 16'h0009,
    16'h00A0, 16'h00A9, 16'h00AE, 16'h20AC, 16'h2122, 16'h2764
  };

  localparam logic [15:0] PLAIN_CASES [13] = '{
    16'h0000, 16'h0001, 16'h001F, 16'h0009, 16'h000A, 16'h000D, 16'h0022,
    16'h0026, 16'h0027, 16'h003C, 16'h003E, 16'h0020, 16'hFFFF
  };

  localparam logic [15:0] ASCII_CASES [12] = '{
    16'h0000, 16'h007E, 16'h007F, 16'h00A0, 16'h00A9, 16'h00AE,
    16'h20AC, 16'h2122, 16'h2764, 16'h2710, 16'hFFFF, 16'h0041
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] code_unit;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_char;
  logic        last;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  int          burst_left;
  bit          rx_hold_req;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  xml_entity_escape_encoder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_unit   (code_unit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last        (last)
  );

  escape_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_unit   (code_unit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last        (last),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (burst_left > 0) return 0;
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1:    return ENTITY_CODES[$urandom_range(0, 13)];
      2:       return 16'($urandom_range(0, 31));
      3, 4:    return 16'($urandom_range(32, 126));
      5:       return 16'($urandom_range(127, 255));
      6: begin
        case ($urandom_range(0, 5))
          0:       return 16'h0000;
          1:       return 16'hFFFF;
          2:       return 16'h007F;
          3:       return 16'h007E;
          4:       return 16'h001F;
          default: return 16'h0020;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transaction; returns at a falling edge
  task automatic send_unit(input logic [15:0] c, input int gap);
    code_unit <= c;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wr_data <= m;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (burst_left > 0) burst_left--;
      else if ($urandom_range(0, 29) == 0) burst_left = 15;
      send_unit(pick_code(), gap_len());
    end
  endtask

  // receiver stall pattern
  initial begin
    int n;
    out_stall <= 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 4);
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        repeat (n) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_valid    <= 1'b0;
    code_unit   <= 16'h0000;
    burst_left  = 0;
    rx_hold_req = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_mode(MODE_PLAIN);
    foreach (PLAIN_CASES[i]) send_unit(PLAIN_CASES[i], gap_len());
    send_random(25);
    drain();

    write_mode(MODE_ASCII);
    foreach (ASCII_CASES[i]) send_unit(ASCII_CASES[i], gap_len());
    // long output hold-off with back-to-back multi-unit inputs
    rx_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_unit(16'($urandom_range(10000, 65535)), 0);
    send_random(15);
    drain();
    send_random(10);
    drain();

    write_mode(MODE_PLAIN);
    send_random(12);
    drain();

    write_mode(MODE_ASCII);
    send_random(12);
    drain();
    repeat (10) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
